// ===== src/mst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_pkg: shared types and constants of the max segment tree
// Beat layouts of both channels, opcode values and the sequencer states.
// ----------------------------------------------------------------------------
package mst_pkg;

    localparam int POS_W       = 10;
    localparam int VAL_W       = 32;
    localparam int LEAVES_DEF  = 1024;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic             op;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] range_high;
        logic [VAL_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [VAL_W-1:0] max_value;
        logic             empty_range;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LEAF_RD,
        ST_LEAF_WR,
        ST_UP_RD,
        ST_UP_WR,
        ST_Q_LOOP,
        ST_Q_LDAT,
        ST_Q_RDAT,
        ST_Q_OUT
    } t_state;

endpackage

// ===== src/mst_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module mst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/max_segment_tree.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_segment_tree: range-maximum store over LEAVES positions
// Bottom-up binary tree of maxima kept in one RAM, walked by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one beat per operation. An update beat (op = 0)
//   raises leaf position to the larger of its old value and value, then
//   rebuilds every ancestor; it gives no output beat. A query beat (op = 1)
//   gives one output beat holding the maximum over position..range_high, or
//   empty_range set with max_value zero when position is above range_high.
//   Positions at or above LEAVES hold zero; updates to them are dropped.
//   One item is in flight at a time: o_in_stall stays high until the
//   sequencer is back in idle.
//   Steps: an update does one RAM read and one write per tree level (through
//   the single RAM port pair), starting at the leaf and ending at the root.
//   A query walks the tree levels from the leaves upward; each leaf or node
//   fetched costs a read and a combine.
//   An empty query goes straight to the output step.
//   Reset: after i_rst_n is released, a clearing pass writes zero to all
//   2*LEAVES RAM words, one per cycle, while the input stays stalled.
//   A finished query result sits in the output register; if the receiver
//   stalls, a following query holds in its last step until that beat leaves,
//   and no beat is taken meanwhile; updates before it are still taken and worked.
// ----------------------------------------------------------------------------
module max_segment_tree #(
    parameter int LEAVES = mst_pkg::LEAVES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mst_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mst_pkg::t_out_beat o_out_data
);

    import mst_pkg::*;

    // Address width of the node RAM, width that can also hold 2*LEAVES
    // (the exclusive right bound of a query), and a compare width that
    // holds both a position field and those node numbers.
    localparam int DEPTH = 2 * LEAVES;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(DEPTH + 1);
    localparam int CW    = (RW > POS_W) ? RW : POS_W;

    t_state     r_state, n_state;
    logic [RW-1:0]    r_n, n_n;
    logic [RW-1:0]    r_l, n_l;
    logic [RW-1:0]    r_r, n_r;
    logic [VAL_W-1:0] r_acc, n_acc;
    logic [VAL_W-1:0] r_val, n_val;
    logic             r_empty, n_empty;
    logic             r_out_valid, n_out_valid;
    t_out_beat        r_out, n_out;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [VAL_W-1:0] ram_rdata;

    // The one shared compare unit: RAM read data against a held operand.
    logic [VAL_W-1:0] cmp_b;
    logic [VAL_W-1:0] cmp_max;

    logic             in_take;
    logic [CW-1:0]    pos_ext;
    logic [CW-1:0]    hi_ext;
    logic [CW-1:0]    hi_clip;
    logic [RW-1:0]    parent;

    assign cmp_b   = (r_state == ST_LEAF_WR) ? r_val : r_acc;
    assign cmp_max = (ram_rdata > cmp_b) ? ram_rdata : cmp_b;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_take    = i_in_valid && (r_state == ST_IDLE);

    assign pos_ext = CW'(i_in_data.position);
    assign hi_ext  = CW'(i_in_data.range_high);
    // Clip the high end of a query to the last leaf.
    assign hi_clip = (hi_ext >= CW'(LEAVES)) ? CW'(LEAVES - 1) : hi_ext;
    assign parent  = r_n >> 1;

    mst_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l     <= n_l;
        r_r     <= n_r;
        r_acc   <= n_acc;
        r_val   <= n_val;
        r_empty <= n_empty;
        r_out   <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_l         = r_l;
        n_r         = r_r;
        n_acc       = r_acc;
        n_val       = r_val;
        n_empty     = r_empty;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we      = 1'b0;
        ram_waddr   = r_n[AW-1:0];
        ram_wdata   = cmp_max;
        ram_raddr   = r_n[AW-1:0];

        case (r_state)
            ST_CLEAR: begin
                // One RAM word cleared per cycle after reset.
                ram_we    = 1'b1;
                ram_wdata = '0;
                n_n       = r_n + RW'(1);
                if (r_n[AW-1:0] == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_take) begin
                    n_val   = i_in_data.value;
                    n_acc   = '0;
                    n_empty = 1'b0;
                    if (i_in_data.op == OP_UPDATE) begin
                        if (pos_ext < CW'(LEAVES)) begin
                            n_n     = RW'(pos_ext + CW'(LEAVES));
                            n_state = ST_LEAF_RD;
                        end
                    end else if (i_in_data.position > i_in_data.range_high) begin
                        n_empty = 1'b1;
                        n_state = ST_Q_OUT;
                    end else if (pos_ext > hi_clip) begin
                        // The range lies wholly above the last leaf.
                        n_state = ST_Q_OUT;
                    end else begin
                        n_l     = RW'(pos_ext + CW'(LEAVES));
                        n_r     = RW'(hi_clip + CW'(LEAVES + 1));
                        n_state = ST_Q_LOOP;
                    end
                end
            end
            ST_LEAF_RD: begin
                n_state = ST_LEAF_WR;
            end
            ST_LEAF_WR: begin
                ram_we  = 1'b1;
                n_acc   = cmp_max;
                n_state = ST_UP_RD;
            end
            ST_UP_RD: begin
                ram_raddr = r_n[AW-1:0] ^ AW'(1);
                n_state   = ST_UP_WR;
            end
            ST_UP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = parent[AW-1:0];
                n_acc     = cmp_max;
                n_n       = parent;
                n_state   = (parent > RW'(1)) ? ST_UP_RD : ST_IDLE;
            end
            ST_Q_LOOP: begin
                if (!(r_l < r_r)) begin
                    n_state = ST_Q_OUT;
                end else if (r_l[0]) begin
                    ram_raddr = r_l[AW-1:0];
                    n_l       = r_l + RW'(1);
                    n_state   = ST_Q_LDAT;
                end else if (r_r[0]) begin
                    ram_raddr = AW'(r_r - RW'(1));
                    n_r       = r_r - RW'(1);
                    n_state   = ST_Q_RDAT;
                end else begin
                    n_l = r_l >> 1;
                    n_r = r_r >> 1;
                end
            end
            ST_Q_LDAT: begin
                n_acc = cmp_max;
                if (r_r[0]) begin
                    ram_raddr = AW'(r_r - RW'(1));
                    n_r       = r_r - RW'(1);
                    n_state   = ST_Q_RDAT;
                end else begin
                    n_l     = r_l >> 1;
                    n_r     = r_r >> 1;
                    n_state = ST_Q_LOOP;
                end
            end
            ST_Q_RDAT: begin
                n_acc   = cmp_max;
                n_l     = r_l >> 1;
                n_r     = r_r >> 1;
                n_state = ST_Q_LOOP;
            end
            ST_Q_OUT: begin
                // Load the output register once the previous beat is gone.
                if (!r_out_valid || !i_out_stall) begin
                    n_out.max_value   = r_acc;
                    n_out.empty_range = r_empty;
                    n_out_valid       = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
